// ----- src/atid_pkg.sv -----
`timescale 1ns / 1ps
package atid_pkg;

  localparam int CHANNELS      = 9;
  localparam int STABLE_TICKS  = 4;
  localparam int SAMPLE_BITS   = 12;
  localparam int THRESH_BITS   = 12;
  localparam int CMP_BITS      = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  localparam int CFG_DATA_BITS = (CHANNELS > THRESH_BITS) ? CHANNELS : THRESH_BITS;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = THRESH_BITS'(2333);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CHANNELS-1:0]    chan_word_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEVEL_THRESHOLD     = 2'd0,
    REG_CHANNEL_ENABLE_MASK = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    chan_word_t stable_inputs;
    chan_word_t rising_flags;
    chan_word_t falling_flags;
    logic       accepted;
  } result_t;

endpackage

// ----- src/atid_in_if.sv -----
`timescale 1ns / 1ps
interface atid_in_if
  import atid_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  sample_t sample_ch4;
  sample_t sample_ch5;
  sample_t sample_ch6;
  sample_t sample_ch7;
  sample_t sample_ch8;
  logic    clear_edges;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
           sample_ch5, sample_ch6, sample_ch7, sample_ch8, clear_edges,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
           sample_ch5, sample_ch6, sample_ch7, sample_ch8, clear_edges,
    output ready
  );
endinterface

// ----- src/atid_out_if.sv -----
`timescale 1ns / 1ps
interface atid_out_if
  import atid_pkg::*;
;
  logic       valid;
  logic       ready;
  chan_word_t stable_inputs;
  chan_word_t rising_flags;
  chan_word_t falling_flags;
  logic       accepted;

  modport source (
    output valid, stable_inputs, rising_flags, falling_flags, accepted,
    input  ready
  );
  modport sink (
    input  valid, stable_inputs, rising_flags, falling_flags, accepted,
    output ready
  );
endinterface

// ----- src/atid_lane.sv -----
`timescale 1ns / 1ps
module atid_lane
  import atid_pkg::*;
(
  input  sample_t                sample,
  input  logic [THRESH_BITS-1:0] threshold,
  input  logic                   enable,
  output logic                   level
);

  logic [CMP_BITS-1:0] sample_ext;
  logic [CMP_BITS-1:0] thresh_ext;

  assign sample_ext = CMP_BITS'(sample);
  assign thresh_ext = CMP_BITS'(threshold);

  // strictly above the threshold reads as one
  assign level = enable && (sample_ext > thresh_ext);

endmodule

// ----- src/atid_merge.sv -----
`timescale 1ns / 1ps
module atid_merge
  import atid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  chan_word_t word,
  input  logic       clear_edges,
  output result_t    result
);

  logic [STABLE_TICKS-1:0] history;
  logic [STABLE_TICKS-1:0] history_next;
  logic [STABLE_TICKS:0]   history_shift;
  chan_word_t              previous_word;
  chan_word_t              debounced_word;
  chan_word_t              debounced_word_next;
  chan_word_t              rising_sticky;
  chan_word_t              rising_sticky_next;
  chan_word_t              falling_sticky;
  chan_word_t              falling_sticky_next;
  chan_word_t              rise_base;
  chan_word_t              fall_base;
  logic                    accept;

  always_comb begin
    history_shift = {history, (word == previous_word)};
    history_next  = history_shift[STABLE_TICKS-1:0];
    accept        = &history_next;

    // clear first so edges found in this tick stay set
    rise_base = clear_edges ? '0 : rising_sticky;
    fall_base = clear_edges ? '0 : falling_sticky;

    if (accept) begin
      rising_sticky_next  = rise_base | (~debounced_word & previous_word);
      falling_sticky_next = fall_base | (debounced_word & ~previous_word);
      debounced_word_next = word;
    end else begin
      rising_sticky_next  = rise_base;
      falling_sticky_next = fall_base;
      debounced_word_next = debounced_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history        <= '0;
      previous_word  <= '0;
      debounced_word <= '0;
      rising_sticky  <= '0;
      falling_sticky <= '0;
    end else if (fire) begin
      history        <= history_next;
      previous_word  <= word;
      debounced_word <= debounced_word_next;
      rising_sticky  <= rising_sticky_next;
      falling_sticky <= falling_sticky_next;
    end
  end

  // result register: payload only, validity lives at the top
  always_ff @(posedge clk) begin
    if (fire) begin
      result.stable_inputs <= debounced_word_next;
      result.rising_flags  <= rising_sticky_next;
      result.falling_flags <= falling_sticky_next;
      result.accepted      <= accept;
    end
  end

endmodule

// ----- src/adc_threshold_input_debounce.sv -----
`timescale 1ns / 1ps
// Nine-channel ADC threshold debouncer. Each input item carries one sample per
// channel; a sample strictly above level_threshold reads as one and is gated
// by channel_enable_mask. The masked word becomes the debounced value once it
// has matched the previous item's word for four items in a row, and edges
// against the old debounced value collect in sticky rising and falling flags
// (clear_edges clears them before the current item's edges are added). One
// result item leaves per input item, in the cycle after acceptance; a new item is
// taken every cycle while the output side keeps up, set by the single
// register stage that holds the debounce state and the result. Configuration
// writes take effect on the next item.
module adc_threshold_input_debounce
  import atid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  atid_in_if.sink                  in,
  atid_out_if.source               out
);

  logic [THRESH_BITS-1:0] level_threshold;
  chan_word_t             channel_enable_mask;
  sample_t                samples [CHANNELS];
  chan_word_t             word;
  logic                   fire;
  logic                   out_valid;
  result_t                result;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold     <= THRESHOLD_RESET;
      channel_enable_mask <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_THRESHOLD:     level_threshold     <= cfg_data[THRESH_BITS-1:0];
        REG_CHANNEL_ENABLE_MASK: channel_enable_mask <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  assign samples[0] = in.sample_ch0;
  assign samples[1] = in.sample_ch1;
  assign samples[2] = in.sample_ch2;
  assign samples[3] = in.sample_ch3;
  assign samples[4] = in.sample_ch4;
  assign samples[5] = in.sample_ch5;
  assign samples[6] = in.sample_ch6;
  assign samples[7] = in.sample_ch7;
  assign samples[8] = in.sample_ch8;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    atid_lane u_lane (
      .sample    (samples[ch]),
      .threshold (level_threshold),
      .enable    (channel_enable_mask[ch]),
      .level     (word[ch])
    );
  end

  // take a new item whenever the result slot is empty or draining
  assign in.ready = !out_valid || out.ready;
  assign fire     = in.valid && in.ready;

  atid_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .word        (word),
    .clear_edges (in.clear_edges),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out.valid         = out_valid;
  assign out.stable_inputs = result.stable_inputs;
  assign out.rising_flags  = result.rising_flags;
  assign out.falling_flags = result.falling_flags;
  assign out.accepted      = result.accepted;

endmodule

// ----- src/atid_checker.sv -----
`timescale 1ns / 1ps
module atid_checker
  import atid_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_clear_edges,
  input logic       out_valid,
  input logic       out_ready,
  input chan_word_t out_stable_inputs,
  input chan_word_t out_rising_flags,
  input chan_word_t out_falling_flags,
  input logic       out_accepted
);

  // no result is pending right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // each accepted item shows a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_stable_inputs)
      && $stable(out_rising_flags) && $stable(out_falling_flags)
      && $stable(out_accepted)))
    else $error("stalled result changed");

  // a clear without a completed window leaves no flags set
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_clear_edges) |=>
      (out_accepted || (out_rising_flags == '0 && out_falling_flags == '0)))
    else $error("edge flags survived a clear");

endmodule

bind adc_threshold_input_debounce atid_checker u_atid_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in.valid),
  .in_ready          (in.ready),
  .in_clear_edges    (in.clear_edges),
  .out_valid         (out.valid),
  .out_ready         (out.ready),
  .out_stable_inputs (out.stable_inputs),
  .out_rising_flags  (out.rising_flags),
  .out_falling_flags (out.falling_flags),
  .out_accepted      (out.accepted)
);
